### src/rzct_pkg.sv
// Shared constants for the rising zero-crossing timer.
package rzct_pkg;

   // Entries in the queue between the sample front end and the interpolation back end.
   localparam int QUEUE_DEPTH = 2;

endpackage

### src/rzct_queue.sv
// Small register queue that decouples the front end from the back end.
module rzct_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = rzct_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/rzct_front.sv
// Front end: baseline removal, sign test, history and crossing count.
module rzct_front #(
   parameter int SAMPLE_BITS   = 16,
   parameter int TIME_BITS     = 32,
   parameter int MAX_CROSSINGS = 16,
   localparam int OFFSET_BITS  = SAMPLE_BITS + 1,
   localparam int COUNT_BITS   = $clog2(MAX_CROSSINGS + 1),
   localparam int JOB_BITS     = 2 * TIME_BITS + 2 * OFFSET_BITS + COUNT_BITS + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [SAMPLE_BITS-1:0] csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample_code,
   input  logic [TIME_BITS-1:0]   req_sample_time,
   input  logic                   req_last_sample,
   output logic                   job_valid,
   input  logic                   job_ready,
   output logic [JOB_BITS-1:0]    job_data
);

   logic [SAMPLE_BITS-1:0] baseline_ff, baseline_in;
   logic [OFFSET_BITS-1:0] prev_offset_ff, prev_offset_in;
   logic [TIME_BITS-1:0]   prev_time_ff, prev_time_in;
   logic                   hist_ff, hist_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;

   logic [OFFSET_BITS-1:0] cur_offset;
   logic [TIME_BITS-1:0]   delta_time;
   logic                   hit, over, accept;

   assign cur_offset = {req_sample_code[SAMPLE_BITS-1], req_sample_code}
                     - {baseline_ff[SAMPLE_BITS-1], baseline_ff};
   assign delta_time = req_sample_time - prev_time_ff;
   assign hit = hist_ff && prev_offset_ff[OFFSET_BITS-1]
             && !cur_offset[OFFSET_BITS-1] && (cur_offset != '0);
   assign over = (count_ff == COUNT_BITS'(MAX_CROSSINGS));

   assign req_ready = job_ready;
   assign accept    = req_valid && req_ready;
   assign job_valid = req_valid && hit;
   assign job_data  = {prev_time_ff, delta_time, prev_offset_ff, cur_offset, count_ff, over};

   always_comb begin
      baseline_in    = baseline_ff;
      prev_offset_in = prev_offset_ff;
      prev_time_in   = prev_time_ff;
      hist_in        = hist_ff;
      count_in       = count_ff;
      if (csr_write_enable) begin
         baseline_in = csr_write_data;
      end
      if (accept) begin
         if (req_last_sample) begin
            prev_offset_in = '0;
            prev_time_in   = '0;
            hist_in        = 1'b0;
            count_in       = '0;
         end else begin
            prev_offset_in = cur_offset;
            prev_time_in   = req_sample_time;
            hist_in        = 1'b1;
            if (hit && !over) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         baseline_ff    <= '0;
         prev_offset_ff <= '0;
         prev_time_ff   <= '0;
         hist_ff        <= 1'b0;
         count_ff       <= '0;
      end else begin
         baseline_ff    <= baseline_in;
         prev_offset_ff <= prev_offset_in;
         prev_time_ff   <= prev_time_in;
         hist_ff        <= hist_in;
         count_ff       <= count_in;
      end
   end

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_CROSSINGS))
      else $error("crossing count above capacity");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_last_sample |=> !hist_ff && (count_ff == '0))
      else $error("history not cleared after last sample");

   a_history_kept: assert property (@(posedge clock) disable iff (reset)
      accept && !req_last_sample |=> hist_ff)
      else $error("history lost after ordinary sample");

endmodule

### src/rzct_back.sv
// Back end: serial multiply and restoring divide for the interpolated time.
module rzct_back #(
   parameter int SAMPLE_BITS   = 16,
   parameter int TIME_BITS     = 32,
   parameter int MAX_CROSSINGS = 16,
   localparam int OFFSET_BITS  = SAMPLE_BITS + 1,
   localparam int COUNT_BITS   = $clog2(MAX_CROSSINGS + 1),
   localparam int JOB_BITS     = 2 * TIME_BITS + 2 * OFFSET_BITS + COUNT_BITS + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  logic [JOB_BITS-1:0]    job_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TIME_BITS-1:0]   rsp_crossing_time,
   output logic [OFFSET_BITS-1:0] rsp_below_value,
   output logic [OFFSET_BITS-1:0] rsp_above_value,
   output logic [COUNT_BITS-1:0]  rsp_crossing_ordinal,
   output logic                   rsp_overflowed
);

   localparam int PROD_BITS = TIME_BITS + OFFSET_BITS;
   localparam int STEP_MAX  = (TIME_BITS > OFFSET_BITS) ? TIME_BITS : OFFSET_BITS;
   localparam int STEP_BITS = $clog2(STEP_MAX + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [TIME_BITS-1:0]   t1_ff, t1_in;
   logic [PROD_BITS-1:0]   mcand_ff, mcand_in;
   logic [OFFSET_BITS-1:0] mplier_ff, mplier_in;
   logic [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [OFFSET_BITS-1:0] den_ff, den_in;
   logic [OFFSET_BITS-1:0] rem_ff, rem_in;
   logic [TIME_BITS-1:0]   quot_ff, quot_in;
   logic [OFFSET_BITS-1:0] below_ff, below_in;
   logic [OFFSET_BITS-1:0] above_ff, above_in;
   logic [COUNT_BITS-1:0]  ord_ff, ord_in;
   logic                   over_ff, over_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [TIME_BITS-1:0]   rsp_time_ff, rsp_time_in;
   logic [OFFSET_BITS-1:0] rsp_below_ff, rsp_below_in;
   logic [OFFSET_BITS-1:0] rsp_above_ff, rsp_above_in;
   logic [COUNT_BITS-1:0]  rsp_ord_ff, rsp_ord_in;
   logic                   rsp_over_ff, rsp_over_in;

   logic [TIME_BITS-1:0]   job_t1, job_dt;
   logic [OFFSET_BITS-1:0] job_below, job_above;
   logic [COUNT_BITS-1:0]  job_ord;
   logic                   job_over;
   logic [PROD_BITS-1:0]   prod_sum;
   logic [OFFSET_BITS:0]   trial, trial_diff;
   logic                   fits;

   assign {job_t1, job_dt, job_below, job_above, job_ord, job_over} = job_data;

   assign prod_sum   = mplier_ff[0] ? prod_ff + mcand_ff : prod_ff;
   assign trial      = {rem_ff, quot_ff[TIME_BITS-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign fits       = (trial >= {1'b0, den_ff});

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_crossing_time    = rsp_time_ff;
   assign rsp_below_value      = rsp_below_ff;
   assign rsp_above_value      = rsp_above_ff;
   assign rsp_crossing_ordinal = rsp_ord_ff;
   assign rsp_overflowed       = rsp_over_ff;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      t1_in        = t1_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      below_in     = below_ff;
      above_in     = above_ff;
      ord_in       = ord_ff;
      over_in      = over_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_time_in  = rsp_time_ff;
      rsp_below_in = rsp_below_ff;
      rsp_above_in = rsp_above_ff;
      rsp_ord_in   = rsp_ord_ff;
      rsp_over_in  = rsp_over_ff;
      job_ready    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               t1_in     = job_t1;
               mcand_in  = PROD_BITS'(job_dt);
               mplier_in = '0 - job_below;
               den_in    = job_above - job_below;
               prod_in   = '0;
               below_in  = job_below;
               above_in  = job_above;
               ord_in    = job_ord;
               over_in   = job_over;
               step_in   = STEP_BITS'(OFFSET_BITS);
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            // add one shifted copy of the time step for each set multiplier bit
            prod_in   = prod_sum;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            step_in   = step_ff - 1'b1;
            if (step_ff == STEP_BITS'(1)) begin
               rem_in   = prod_sum[PROD_BITS-1:TIME_BITS];
               quot_in  = prod_sum[TIME_BITS-1:0];
               step_in  = STEP_BITS'(TIME_BITS);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // one quotient bit per cycle; dividend bits shift out as quotient shifts in
            rem_in  = fits ? trial_diff[OFFSET_BITS-1:0] : trial[OFFSET_BITS-1:0];
            quot_in = {quot_ff[TIME_BITS-2:0], fits};
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_BITS'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = t1_ff + quot_ff;
               rsp_below_in = below_ff;
               rsp_above_in = above_ff;
               rsp_ord_in   = ord_ff;
               rsp_over_in  = over_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      t1_ff        <= t1_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      prod_ff      <= prod_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      below_ff     <= below_in;
      above_ff     <= above_in;
      ord_ff       <= ord_in;
      over_ff      <= over_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_below_ff <= rsp_below_in;
      rsp_above_ff <= rsp_above_in;
      rsp_ord_ff   <= rsp_ord_in;
      rsp_over_ff  <= rsp_over_in;
   end

   a_signs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_below_ff[OFFSET_BITS-1] && !rsp_above_ff[OFFSET_BITS-1]
                       && (rsp_above_ff != '0))
      else $error("result samples do not straddle zero");

   a_overflow_ordinal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_over_ff |-> (rsp_ord_ff == COUNT_BITS'(MAX_CROSSINGS)))
      else $error("overflowed result without saturated ordinal");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("partial remainder not below divisor");

endmodule

### src/rising_zero_crossing_timer.sv
// Top level of the rising zero-crossing timer.
//
// Usage: samples enter on the req_ channel (valid/ready), one item per
// accepted edge: a signed code, a timestamp with 8 fractional bits and a
// last-sample mark. The csr_ port writes the baseline; write it only while
// the block is idle. Each rising crossing (offset sample strictly below zero
// followed by one strictly above zero) yields one item on the rsp_ channel.
// Samples without a crossing produce nothing.
// Each crossing item passes through the queue to the back end, where the
// shift-add multiply (one multiplier bit a cycle) and the restoring divide
// (one quotient bit a cycle) produce the interpolated time.
// The front end takes one sample a cycle while the two-entry queue has
// room; the back end works on one crossing at a time and takes the next
// only once its result has gone to the output register.
// Reset clears the baseline, the history, the count, the queue and the
// output valid flag. When the receiver stalls, the result holds in the output
// register, the back end waits, the queue fills and then req_ready drops.
module rising_zero_crossing_timer #(
   parameter int SAMPLE_BITS   = 16,
   parameter int TIME_BITS     = 32,
   parameter int MAX_CROSSINGS = 16,
   localparam int OFFSET_BITS  = SAMPLE_BITS + 1,
   localparam int COUNT_BITS   = $clog2(MAX_CROSSINGS + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [SAMPLE_BITS-1:0] csr_write_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample_code,
   input  logic [TIME_BITS-1:0]   req_sample_time,
   input  logic                   req_last_sample,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [TIME_BITS-1:0]   rsp_crossing_time,
   output logic [OFFSET_BITS-1:0] rsp_below_value,
   output logic [OFFSET_BITS-1:0] rsp_above_value,
   output logic [COUNT_BITS-1:0]  rsp_crossing_ordinal,
   output logic                   rsp_overflowed
);

   // job: t1, t2 - t1, below, above, ordinal, overflow flag
   localparam int JOB_BITS = 2 * TIME_BITS + 2 * OFFSET_BITS + COUNT_BITS + 1;

   logic                push_valid, push_ready;
   logic [JOB_BITS-1:0] push_data;
   logic                pop_valid, pop_ready;
   logic [JOB_BITS-1:0] pop_data;

   // classify samples and keep the history
   rzct_front #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .TIME_BITS     (TIME_BITS),
      .MAX_CROSSINGS (MAX_CROSSINGS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_code  (req_sample_code),
      .req_sample_time  (req_sample_time),
      .req_last_sample  (req_last_sample),
      .job_valid        (push_valid),
      .job_ready        (push_ready),
      .job_data         (push_data)
   );

   // hold pending crossings while the interpolator is busy
   rzct_queue #(
      .WIDTH (JOB_BITS),
      .DEPTH (rzct_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // interpolate the crossing time and drive the result register
   rzct_back #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .TIME_BITS     (TIME_BITS),
      .MAX_CROSSINGS (MAX_CROSSINGS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .job_valid            (pop_valid),
      .job_ready            (pop_ready),
      .job_data             (pop_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_crossing_time    (rsp_crossing_time),
      .rsp_below_value      (rsp_below_value),
      .rsp_above_value      (rsp_above_value),
      .rsp_crossing_ordinal (rsp_crossing_ordinal),
      .rsp_overflowed       (rsp_overflowed)
   );

endmodule

### tb/sv/tb_rising_zero_crossing_timer.sv
// Self-checking testbench for the rising zero-crossing timer, with a crossing scoreboard.
module tb_rising_zero_crossing_timer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS   = 16;
   localparam int TIME_BITS     = 32;
   localparam int MAX_CROSSINGS = 16;
   localparam int OFFSET_BITS   = SAMPLE_BITS + 1;
   localparam int COUNT_BITS    = $clog2(MAX_CROSSINGS + 1);

   // Settle time before a register write: crossing latency plus margin.
   localparam int SETTLE_CYCLES = OFFSET_BITS + TIME_BITS + 2 + 10;
   // Percent chance, per draw, that either side idles.
   localparam int IDLE_PCT      = 24;

   typedef struct {
      logic [TIME_BITS-1:0]   crossing_time;
      logic [OFFSET_BITS-1:0] below_value;
      logic [OFFSET_BITS-1:0] above_value;
      logic [COUNT_BITS-1:0]  crossing_ordinal;
      logic                   overflowed;
   } crossing_type;

   // Tracks the waveform history and holds the crossings still owed by the block.
   class crossing_scoreboard;
      logic signed [SAMPLE_BITS-1:0] baseline = '0;
      logic signed [OFFSET_BITS-1:0] prev_offset = '0;
      logic [TIME_BITS-1:0]          prev_time = '0;
      bit                            history_valid = 1'b0;
      int unsigned                   crossing_count = 0;
      crossing_type                  owed_q[$];
      int                            failures = 0;

      function int pending();
         return owed_q.size();
      endfunction

      function void note_sample(logic [SAMPLE_BITS-1:0] code, logic [TIME_BITS-1:0] stamp,
                                logic last);
         logic signed [OFFSET_BITS-1:0] cur;
         logic [TIME_BITS-1:0]          dt;
         longint unsigned               span, num, den, scaled;
         crossing_type                  c;
         bit                            over;
         cur = $signed({code[SAMPLE_BITS-1], code}) -
               $signed({baseline[SAMPLE_BITS-1], baseline});
         if (history_valid && prev_offset < 0 && cur > 0) begin
            // Interpolate between the two offset samples; the time gap wraps.
            dt     = stamp - prev_time;
            span   = 64'(dt);
            num    = 64'(-int'(prev_offset));
            den    = 64'(int'(cur) - int'(prev_offset));
            scaled = (span / den) * num + ((span % den) * num) / den;
            over   = crossing_count >= MAX_CROSSINGS;
            c.crossing_time    = prev_time + scaled[TIME_BITS-1:0];
            c.below_value      = prev_offset;
            c.above_value      = cur;
            c.crossing_ordinal = over ? COUNT_BITS'(MAX_CROSSINGS) : COUNT_BITS'(crossing_count);
            c.overflowed       = over;
            if (!over)
               crossing_count++;
            owed_q.push_back(c);
         end
         if (last) begin
            prev_offset    = '0;
            prev_time      = '0;
            history_valid  = 1'b0;
            crossing_count = 0;
         end else begin
            prev_offset   = cur;
            prev_time     = stamp;
            history_valid = 1'b1;
         end
      endfunction

      function void report_failure(string what, crossing_type want, crossing_type got);
         failures++;
         if (failures <= 10)
            $display({"%0t %s: expected time=%h below=%h above=%h ord=%0d ovf=%b,",
                      " got time=%h below=%h above=%h ord=%0d ovf=%b"},
                     $realtime, what,
                     want.crossing_time, want.below_value, want.above_value,
                     want.crossing_ordinal, want.overflowed,
                     got.crossing_time, got.below_value, got.above_value,
                     got.crossing_ordinal, got.overflowed);
      endfunction

      function void check_crossing(crossing_type got);
         crossing_type want;
         if (owed_q.size() == 0) begin
            want = '{default: '0};
            report_failure("unexpected crossing", want, got);
            return;
         end
         want = owed_q.pop_front();
         if (got.crossing_time !== want.crossing_time ||
             got.below_value !== want.below_value ||
             got.above_value !== want.above_value ||
             got.crossing_ordinal !== want.crossing_ordinal ||
             got.overflowed !== want.overflowed)
            report_failure("crossing mismatch", want, got);
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [SAMPLE_BITS-1:0] csr_write_data;
   logic                   req_valid;
   logic                   req_ready;
   logic [SAMPLE_BITS-1:0] req_sample_code;
   logic [TIME_BITS-1:0]   req_sample_time;
   logic                   req_last_sample;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [TIME_BITS-1:0]   rsp_crossing_time;
   logic [OFFSET_BITS-1:0] rsp_below_value;
   logic [OFFSET_BITS-1:0] rsp_above_value;
   logic [COUNT_BITS-1:0]  rsp_crossing_ordinal;
   logic                   rsp_overflowed;

   crossing_scoreboard board;
   bit                 calm = 1'b0;   // set: neither side idles
   int                 current_baseline = 0;
   int                 items_sent = 0;

   rising_zero_crossing_timer #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .TIME_BITS    (TIME_BITS),
      .MAX_CROSSINGS(MAX_CROSSINGS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_sample_code     (req_sample_code),
      .req_sample_time     (req_sample_time),
      .req_last_sample     (req_last_sample),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_crossing_time   (rsp_crossing_time),
      .rsp_below_value     (rsp_below_value),
      .rsp_above_value     (rsp_above_value),
      .rsp_crossing_ordinal(rsp_crossing_ordinal),
      .rsp_overflowed      (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Bound the run well beyond the slowest correct one.
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   // Sample the handshakes at the edge itself; values read here are the pre-edge ones,
   // so the outcome does not depend on process order within the time step.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_sample(req_sample_code, req_sample_time, req_last_sample);
   end

   always @(posedge clock) begin
      crossing_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.crossing_time    = rsp_crossing_time;
         got.below_value      = rsp_below_value;
         got.above_value      = rsp_above_value;
         got.crossing_ordinal = rsp_crossing_ordinal;
         got.overflowed       = rsp_overflowed;
         board.check_crossing(got);
      end
   end

   // Stall the result side at random, except during a calm phase.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Present one sample and hold it until accepted. Valid is left high on return;
   // the next call either replaces the payload or drops valid for an idle cycle.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] code,
                              input logic [TIME_BITS-1:0] stamp, input logic last);
      if (!calm)
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid       <= 1'b1;
      req_sample_code <= code;
      req_sample_time <= stamp;
      req_last_sample <= last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   // Drop valid, let the last accepted sample reach the scoreboard, drain every
   // owed crossing, then let the back end settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_baseline(input int value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value[SAMPLE_BITS-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      current_baseline = value;
      board.baseline   = value[SAMPLE_BITS-1:0];
   endtask

   // Map an offset around the baseline to a sample code, clamped to the code range.
   function automatic logic [SAMPLE_BITS-1:0] code_for(input int target);
      int v;
      v = current_baseline + target;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return v[SAMPLE_BITS-1:0];
   endfunction

   // One waveform: offsets swing around the baseline, times mostly advance,
   // the final sample carries the last mark; a few items are pure noise.
   task automatic run_waveform(input int length, input int flip_pct);
      int                   sign;
      int                   mag;
      logic [TIME_BITS-1:0] stamp;
      stamp = $urandom();
      sign  = ($urandom_range(1) == 1) ? 1 : -1;
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(99) < flip_pct)
            sign = -sign;
         case ($urandom_range(15))
            0:       mag = 0;
            1, 2, 3: mag = $urandom_range(65535, 1);
            default: mag = $urandom_range(300, 1);
         endcase
         case ($urandom_range(19))
            0:       stamp += $urandom_range(1 << 20);
            1:       stamp = $urandom();   // jump, possibly backward
            default: stamp += $urandom_range(1000);
         endcase
         if ($urandom_range(19) == 0)
            send_sample(SAMPLE_BITS'($urandom()), TIME_BITS'($urandom()),
                        1'($urandom_range(1)));
         else
            send_sample(code_for(sign * mag), stamp, i == length - 1);
      end
   endtask

   initial begin
      int goal;
      int base;
      board = new;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_sample_code  <= '0;
      req_sample_time  <= '0;
      req_last_sample  <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part at baseline zero.
      write_baseline(0);
      send_sample(SAMPLE_BITS'(-5), 32'd100, 1'b0);     // first sample: no history, no crossing
      send_sample(SAMPLE_BITS'(7), 32'd356, 1'b0);      // plain rising crossing
      send_sample(SAMPLE_BITS'(0), 32'd400, 1'b0);      // zero offset
      send_sample(SAMPLE_BITS'(-3), 32'd500, 1'b0);
      send_sample(SAMPLE_BITS'(0), 32'd600, 1'b0);      // zero in between blocks the crossing
      send_sample(SAMPLE_BITS'(4), 32'd700, 1'b0);
      send_sample(SAMPLE_BITS'(-1), 32'd800, 1'b0);
      send_sample(SAMPLE_BITS'(1), 32'd801, 1'b0);      // smallest swing
      send_sample(SAMPLE_BITS'(-32768), 32'd900, 1'b0);
      send_sample(SAMPLE_BITS'(32767), 32'd1000, 1'b0); // full code swing
      send_sample(SAMPLE_BITS'(-2), 32'd2000, 1'b0);
      send_sample(SAMPLE_BITS'(2), 32'd2100, 1'b1);     // crossing on the last sample, then clear
      send_sample(SAMPLE_BITS'(-4), 32'd2200, 1'b0);    // new waveform starts fresh
      send_sample(SAMPLE_BITS'(6), 32'd2300, 1'b0);     // ordinal back at zero
      send_sample(SAMPLE_BITS'(-10), 32'd5000, 1'b0);
      send_sample(SAMPLE_BITS'(10), 32'd4000, 1'b0);    // time steps backward: gap wraps
      send_sample(SAMPLE_BITS'(-7), 32'hFFFF_FF00, 1'b0);
      send_sample(SAMPLE_BITS'(9), 32'hFFFF_FFFF, 1'b0); // top of the time range
      send_sample(SAMPLE_BITS'(-1), 32'd0, 1'b0);
      send_sample(SAMPLE_BITS'(3), 32'd0, 1'b0);        // zero time gap
      send_sample(SAMPLE_BITS'(0), 32'd0, 1'b1);

      // Extreme baselines give the widest offsets: -65535 then +65535.
      write_baseline(32767);
      send_sample(SAMPLE_BITS'(-32768), 32'd0, 1'b0);
      write_baseline(-32768);
      send_sample(SAMPLE_BITS'(32767), 32'hFFFF_FFFF, 1'b1);

      // Random phases, each under a fresh baseline; one phase runs with no idling.
      for (int phase = 0; phase < 8; phase++) begin
         if ($urandom_range(3) == 0)
            base = int'($urandom_range(65535)) - 32768;
         else
            base = int'($urandom_range(4000)) - 2000;
         write_baseline(base);
         calm = (phase == 3);
         goal = items_sent + 75;
         while (items_sent < goal)
            if ($urandom_range(4) == 0)
               run_waveform($urandom_range(90, 40), 80);   // long: run past capacity
            else
               run_waveform($urandom_range(12, 2), 40);
      end
      calm = 1'b0;

      wait_idle();
      if (board.failures == 0 && board.pending() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### filelist.f
src/rzct_pkg.sv
src/rzct_queue.sv
src/rzct_front.sv
src/rzct_back.sv
src/rising_zero_crossing_timer.sv
tb/sv/tb_rising_zero_crossing_timer.sv
